>>> rtl/fmsaw_pkg.sv
// Shared types and fixed-point constants for the feedback sawtooth oscillator.
// Used by the sine table module and the top level; depends on nothing.
`default_nettype none

package fmsaw_pkg;

  // Feedback value y and the signed sine value, both Q2.16.
  localparam int FB_W       = 18;
  // Magnitude of one quarter-wave table entry, 0 to 65536.
  localparam int SINE_MAG_W = 17;

  // Operands of the shared multiplier: a signed Q.16 value and an unsigned gain.
  localparam int MUL_A_W    = 21;
  localparam int MUL_B_W    = 17;
  localparam int MUL_W      = MUL_A_W + MUL_B_W;

  // Register widths.
  localparam int PINC_W     = 23;
  localparam int FBS_W      = 16;
  localparam int DC_W       = 14;
  localparam int GAIN_W     = 16;
  localparam int GAIN_RESET = 32768;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PHASE_INC,
    REG_FB_SCALE,
    REG_DC_OFFSET,
    REG_NORM_GAIN
  } cfg_reg_t;

endpackage : fmsaw_pkg

`default_nettype wire

>>> rtl/fmsaw_sine_rom.sv
// Quarter-wave sine table with quadrant folding and a registered read.
// The table is built at elaboration; depends on fmsaw_pkg.
`default_nettype none

module fmsaw_sine_rom #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  wire logic                             clk,
  input  wire logic [SINE_ADDR_BITS-1:0]        addr,
  output logic signed [fmsaw_pkg::FB_W-1:0]     sine_r
);
  import fmsaw_pkg::*;

  localparam int QLEN  = 1 << (SINE_ADDR_BITS - 2);
  localparam int IDX_W = SINE_ADDR_BITS - 1;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // One Taylor recurrence step before the division: t * x^2 in Q2.30.
  function automatic logic [63:0] tstep(input logic [63:0] t, input logic [63:0] x);
    return (((t * x) >> 30) * x) >> 30;
  endfunction

  // Entry i = round(sin(pi/2 * i/QLEN) * 2^16) by an eleven-term truncating series.
  function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        rounded;
    x   = (64'(i) * PI_Q30) >> (SINE_ADDR_BITS - 1);
    t   = x;
    sum = $signed(x);
    t = tstep(t, x) / 64'd6;   sum = sum - $signed(t);
    t = tstep(t, x) / 64'd20;  sum = sum + $signed(t);
    t = tstep(t, x) / 64'd42;  sum = sum - $signed(t);
    t = tstep(t, x) / 64'd72;  sum = sum + $signed(t);
    t = tstep(t, x) / 64'd110; sum = sum - $signed(t);
    t = tstep(t, x) / 64'd156; sum = sum + $signed(t);
    t = tstep(t, x) / 64'd210; sum = sum - $signed(t);
    t = tstep(t, x) / 64'd272; sum = sum + $signed(t);
    t = tstep(t, x) / 64'd342; sum = sum - $signed(t);
    t = tstep(t, x) / 64'd420; sum = sum + $signed(t);
    if (sum < 0) begin
      sum = '0;
    end
    rounded = ($unsigned(sum) + 64'd8192) >> 14;
    return rounded[SINE_MAG_W-1:0];
  endfunction

  logic [SINE_MAG_W-1:0] qtab [QLEN+1];

  // Constant table contents.
  for (genvar gi = 0; gi <= QLEN; gi++) begin : g_tab
    assign qtab[gi] = sine_entry(gi);
  end

  logic [1:0]            quad;
  logic [IDX_W-1:0]      j;
  logic [IDX_W-1:0]      idx;
  logic [SINE_MAG_W-1:0] mag;

  // Fold the address into the first quadrant; odd quadrants read mirrored.
  always_comb begin
    quad = addr[SINE_ADDR_BITS-1 -: 2];
    j    = {1'b0, addr[SINE_ADDR_BITS-3:0]};
    idx  = quad[0] ? IDX_W'(QLEN) - j : j;
    mag  = qtab[idx];
  end

  // The lower half-turn is negated.
  always_ff @(posedge clk) begin
    if (quad[1]) begin
      sine_r <= -$signed({1'b0, mag});
    end else begin
      sine_r <= $signed({1'b0, mag});
    end
  end

endmodule : fmsaw_sine_rom

`default_nettype wire

>>> rtl/fm_feedback_saw_oscillator_top.sv
// Top level of the feedback FM sawtooth oscillator: registers, sequencer, multiplier.
// Depends on fmsaw_pkg and fmsaw_sine_rom.
`default_nettype none

// Each accepted beat with advance high produces one saturated Q2.14 sample of a
// quasi-bandlimited sawtooth; a beat with advance low restarts phase and
// feedback and produces a zero sample. An advancing beat steps through the
// sequencer states MOD, ADDR, AVG, BOOST, GAIN and DONE, using one shared
// multiplier twice per sample (modulation depth, then output gain) and the
// registered sine table read; a restart goes straight to DONE. The block
// accepts no beat while a sample is being worked on, but a finished sample
// held in the output register does not stop the next beat being taken.
// Registers sit on an APB-style port at byte addresses 0, 4, 8 and 12 and
// should be written while the block is idle.
module fm_feedback_saw_oscillator_top #(
  parameter int PHASE_BITS     = 24,
  parameter int SAMPLE_BITS    = 16,
  parameter int SINE_ADDR_BITS = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_advance,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]           out_sample,
  output logic                                    out_clipped,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fmsaw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [fmsaw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fmsaw_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                    pready
);
  import fmsaw_pkg::*;

  localparam int RS    = 33 - SAMPLE_BITS;
  localparam int RND_W = MUL_W + 1;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd1 <<< (RS - 1));
  localparam logic signed [RND_W-1:0] SMAX = RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SMIN = -SMAX - RND_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_ADDR,
    S_AVG,
    S_BOOST,
    S_GAIN,
    S_DONE
  } state_t;

  // Configuration registers
  logic [PINC_W-1:0] pinc_r;
  logic [FBS_W-1:0]  fbs_r;
  logic [DC_W-1:0]   dc_r;
  logic [GAIN_W-1:0] gain_r;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pinc_r <= '0;
      fbs_r  <= '0;
      dc_r   <= '0;
      gain_r <= GAIN_W'(GAIN_RESET);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_PHASE_INC: pinc_r <= pwdata[PINC_W-1:0];
        REG_FB_SCALE:  fbs_r  <= pwdata[FBS_W-1:0];
        REG_DC_OFFSET: dc_r   <= pwdata[DC_W-1:0];
        REG_NORM_GAIN: gain_r <= pwdata[GAIN_W-1:0];
        default:       pinc_r <= pinc_r;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_sel)
      REG_PHASE_INC: prdata = CFG_DATA_W'(pinc_r);
      REG_FB_SCALE:  prdata = CFG_DATA_W'(fbs_r);
      REG_DC_OFFSET: prdata = CFG_DATA_W'(dc_r);
      REG_NORM_GAIN: prdata = CFG_DATA_W'(gain_r);
      default:       prdata = '0;
    endcase
  end

  // Phase increment aligned to PHASE_BITS-1 fraction bits.
  logic [PHASE_BITS-1:0] inc_al;
  if (PHASE_BITS >= 24) begin : g_inc_up
    assign inc_al = {{(PHASE_BITS - PINC_W){1'b0}}, pinc_r} << (PHASE_BITS - 24);
  end else begin : g_inc_dn
    assign inc_al = PHASE_BITS'(pinc_r >> (24 - PHASE_BITS));
  end

  // Oscillator state and working registers
  state_t                       state_r;
  logic [PHASE_BITS-1:0]        phase_r;
  logic signed [FB_W-1:0]       fb_r;
  logic signed [FB_W-1:0]       prev_r;
  logic signed [MUL_A_W-1:0]    opnd_r;
  logic signed [MUL_W-1:0]      prod_r;
  logic                         zero_r;
  logic                         out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                         clip_r;

  // Shared multiplier operand selection.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_p;

  always_comb begin
    if (state_r == S_GAIN) begin
      mul_a = opnd_r;
      mul_b = $signed({1'b0, gain_r});
    end else begin
      mul_a = MUL_A_W'(fb_r);
      mul_b = $signed({1'b0, fbs_r});
    end
    mul_p = mul_a * mul_b;
  end

  // Modulated angle and table address.
  logic signed [MUL_W-1:0]      modsh;
  logic [PHASE_BITS-1:0]        angle;
  logic [SINE_ADDR_BITS-1:0]    sine_addr;
  logic signed [FB_W-1:0]       sine_r;

  assign modsh     = prod_r >>> (33 - PHASE_BITS);
  assign angle     = phase_r + modsh[PHASE_BITS-1:0];
  assign sine_addr = angle[PHASE_BITS-2 -: SINE_ADDR_BITS];

  fmsaw_sine_rom #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_rom (
    .clk   (clk),
    .addr  (sine_addr),
    .sine_r(sine_r)
  );

  // Averaging of the sine with the previous feedback value.
  logic signed [FB_W:0]   avg_sum;
  logic signed [FB_W-1:0] fb_nxt;

  assign avg_sum = {fb_r[FB_W-1], fb_r} + {sine_r[FB_W-1], sine_r};
  assign fb_nxt  = avg_sum[FB_W:1];

  // High-frequency boost plus DC compensation, the gain multiplicand.
  logic signed [MUL_A_W-1:0] y5;
  logic signed [MUL_A_W-1:0] yp3;
  logic signed [MUL_A_W-1:0] boost_diff;
  logic signed [MUL_A_W-1:0] opnd_nxt;

  always_comb begin
    y5         = (MUL_A_W'(fb_r) <<< 2) + MUL_A_W'(fb_r);
    yp3        = (MUL_A_W'(prev_r) <<< 1) + MUL_A_W'(prev_r);
    boost_diff = y5 - yp3;
    opnd_nxt   = (boost_diff >>> 1) + $signed({{(MUL_A_W - DC_W - 2){1'b0}}, dc_r, 2'b00});
  end

  // Rounding and saturation of the scaled sample.
  logic signed [RND_W-1:0]       rnd_sum;
  logic signed [RND_W-1:0]       rnd_s;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;
  logic                          clip_nxt;

  always_comb begin
    rnd_sum = RND_W'(prod_r) + RND_HALF;
    rnd_s   = rnd_sum >>> RS;
    if (zero_r) begin
      sample_nxt = '0;
      clip_nxt   = 1'b0;
    end else if (rnd_s > SMAX) begin
      sample_nxt = SMAX[SAMPLE_BITS-1:0];
      clip_nxt   = 1'b1;
    end else if (rnd_s < SMIN) begin
      sample_nxt = SMIN[SAMPLE_BITS-1:0];
      clip_nxt   = 1'b1;
    end else begin
      sample_nxt = rnd_s[SAMPLE_BITS-1:0];
      clip_nxt   = 1'b0;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_sample  = sample_r;
  assign out_clipped = clip_r;

  // Sequencer: one sample walks through the shared multiplier twice.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      fb_r        <= '0;
      prev_r      <= '0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
      opnd_r      <= '0;
      prod_r      <= '0;
      sample_r    <= '0;
      clip_r      <= 1'b0;
    end else begin
      // The result register is loaded from the done state and emptied by a taken beat.
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_advance) begin
              phase_r <= phase_r + inc_al;
              zero_r  <= 1'b0;
              state_r <= S_MOD;
            end else begin
              phase_r <= '0;
              fb_r    <= '0;
              prev_r  <= '0;
              zero_r  <= 1'b1;
              state_r <= S_DONE;
            end
          end
        end
        S_MOD: begin
          prod_r  <= mul_p;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          state_r <= S_AVG;
        end
        S_AVG: begin
          fb_r    <= fb_nxt;
          state_r <= S_BOOST;
        end
        S_BOOST: begin
          opnd_r  <= opnd_nxt;
          prev_r  <= fb_r;
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          prod_r  <= mul_p;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            sample_r    <= sample_nxt;
            clip_r      <= clip_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule : fm_feedback_saw_oscillator_top

`default_nettype wire

>>> rtl/fmsaw_checker.sv
// Port-level checks for the feedback sawtooth oscillator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fmsaw_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_sample,
  input wire logic                   out_clipped
);

  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // A waiting result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clipped))
    else $error("result beat changed while stalled");

  // The block is busy in the cycle after taking a beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a beat");

  // A clipped sample sits at one of the saturation limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_sample == SAT_HI) || (out_sample == SAT_LO))
    else $error("clipped sample not at a limit");

  // Reset leaves no result pending and the input side open.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left the block busy");

endmodule : fmsaw_checker

bind fm_feedback_saw_oscillator_top fmsaw_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_fmsaw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .out_clipped(out_clipped)
);

`default_nettype wire
